>>> sv/sample_ring_with_ack_window_defines.svh
// assertion macros shared by the checker
`ifndef SAMPLE_RING_WITH_ACK_WINDOW_DEFINES_SVH
`define SAMPLE_RING_WITH_ACK_WINDOW_DEFINES_SVH

// checked outside reset
`define SRACK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SRACK_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/srack_pkg.sv
`timescale 1ns / 1ps

package srack_pkg;

    localparam int CHANNELS   = 4;
    localparam int RING_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(RING_DEPTH);

    localparam logic [31:0] WINDOW_LIMIT = 32'(RING_DEPTH - 1);

    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_STOP  = 3'd1;
    localparam logic [2:0] CMD_TICK  = 3'd2;
    localparam logic [2:0] CMD_ACK   = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [11:0] sample_mv;
        logic [1:0]  channel;
        logic [31:0] read_index;
        logic [31:0] ack_count;
    } item_t;

    typedef struct packed {
        logic [11:0] read_sample;
        logic        tick_dropped;
        logic [31:0] produced_count;
        logic [31:0] overflow_total;
        logic        is_running;
    } result_t;

endpackage

>>> sv/srack_ram.sv
`timescale 1ns / 1ps

module srack_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/sample_ring_with_ack_window.sv
`timescale 1ns / 1ps
// a beat accepted at one edge gives its result with done in the next cycle
// throughput: one beat per cycle, busy stays low; at most one write and one read of the ram per beat
// the receiver cannot stall, so each result is shown for exactly one cycle
// reset clears running, the write, drop and acknowledge counters and the done strobe
// the sample ram is not cleared; entries are defined once written

module sample_ring_with_ack_window (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  srack_pkg::item_t  item,
    output logic              done,
    output srack_pkg::result_t result
);

    import srack_pkg::*;

    logic                running_reg;
    logic                running_next;
    logic [31:0]         write_count_reg;
    logic [31:0]         write_count_next;
    logic [31:0]         drop_count_reg;
    logic [31:0]         drop_count_next;
    logic [31:0]         acked_reg  [CHANNELS];
    logic [31:0]         acked_next [CHANNELS];
    logic [CHANNELS-1:0] full_vec;
    logic                accept;
    logic                wr_en;
    logic                dropped_next;

    logic                done_reg;
    logic                rd_sel_reg;
    logic                dropped_reg;
    logic [31:0]         produced_reg;
    logic [31:0]         overflow_reg;
    logic                is_running_reg;
    logic [11:0]         ram_rdata;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            full_vec[c] = (write_count_reg - acked_reg[c]) >= WINDOW_LIMIT;
        end
    end

    always_comb
    begin
        running_next     = running_reg;
        write_count_next = write_count_reg;
        drop_count_next  = drop_count_reg;
        for (int c = 0; c < CHANNELS; c++)
        begin
            acked_next[c] = acked_reg[c];
        end
        wr_en        = 1'b0;
        dropped_next = 1'b0;
        if (accept)
        begin
            case (item.cmd)
                CMD_START:
                begin
                    write_count_next = '0;
                    drop_count_next  = '0;
                    running_next     = 1'b1;
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        acked_next[c] = '0;
                    end
                end
                CMD_STOP:
                begin
                    running_next = 1'b0;
                end
                CMD_TICK:
                begin
                    if (running_reg)
                    begin
                        if (|full_vec)
                        begin
                            drop_count_next = drop_count_reg + 32'd1;
                            dropped_next    = 1'b1;
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            write_count_next = write_count_reg + 32'd1;
                        end
                    end
                end
                CMD_ACK:
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (int'(item.channel) == c && item.ack_count > acked_reg[c])
                        begin
                            acked_next[c] = item.ack_count;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg     <= 1'b0;
            write_count_reg <= '0;
            drop_count_reg  <= '0;
            done_reg        <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                acked_reg[c] <= '0;
            end
        end
        else
        begin
            running_reg     <= running_next;
            write_count_reg <= write_count_next;
            drop_count_reg  <= drop_count_next;
            done_reg        <= accept;
            for (int c = 0; c < CHANNELS; c++)
            begin
                acked_reg[c] <= acked_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_sel_reg     <= (item.cmd == CMD_READ);
            dropped_reg    <= dropped_next;
            produced_reg   <= write_count_next;
            overflow_reg   <= drop_count_next;
            is_running_reg <= running_next;
        end
    end

    srack_ram #(
        .WIDTH (12),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (write_count_reg[ADDR_W-1:0]),
        .wdata (item.sample_mv),
        .re    (accept),
        .raddr (item.read_index[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign done                  = done_reg;
    assign result.read_sample    = rd_sel_reg ? ram_rdata : 12'd0;
    assign result.tick_dropped   = dropped_reg;
    assign result.produced_count = produced_reg;
    assign result.overflow_total = overflow_reg;
    assign result.is_running     = is_running_reg;

endmodule

>>> sv/srack_checker.sv
`timescale 1ns / 1ps
`include "sample_ring_with_ack_window_defines.svh"

module srack_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input srack_pkg::item_t   item,
    input logic               done,
    input srack_pkg::result_t result
);

    import srack_pkg::*;

    logic beat;
    logic start_beat;
    logic drop_beat;
    logic counters_clear;

    assign beat           = start && !busy;
    assign start_beat     = beat && (item.cmd == CMD_START);
    assign drop_beat      = done && result.tick_dropped;
    assign counters_clear = result.is_running && (result.produced_count == 32'd0)
                            && (result.overflow_total == 32'd0);

    `SRACK_ASSERT(a_beat_gives_result, beat |=> done, "accepted beat gave no result")
    `SRACK_ASSERT(a_no_spurious_result, !beat |=> !done, "result without a beat")
    `SRACK_ASSERT(a_drop_only_running, drop_beat |-> result.is_running, "drop while stopped")
    `SRACK_ASSERT(a_start_clears, start_beat |=> done && counters_clear, "start left counters")
    `SRACK_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !done, "done during reset")

endmodule

bind sample_ring_with_ack_window srack_checker u_srack_checker (.*);
